// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sipf_pkg.sv -----
// Types, constants and microcode ROM of the servo instruction packet framer.
// No dependencies; used by every module of the framer.
package sipf_pkg;

    localparam int STEP_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // command kinds
    localparam logic [2:0] KIND_PING       = 3'd0;
    localparam logic [2:0] KIND_READ_BYTE  = 3'd1;
    localparam logic [2:0] KIND_READ_WORD  = 3'd2;
    localparam logic [2:0] KIND_WRITE_BYTE = 3'd3;
    localparam logic [2:0] KIND_WRITE_WORD = 3'd4;
    localparam logic [2:0] KIND_READ_TABLE = 3'd5;
    localparam logic [2:0] KIND_SYNC_ARM   = 3'd6;
    localparam logic [2:0] KIND_NONE       = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_ID    = 2'd1;

    localparam logic [7:0] SHOULDER_ID_RST = 8'd1;
    localparam logic [7:0] ELBOW_ID_RST    = 8'd2;

    // protocol bytes
    localparam logic [7:0] HEADER_BYTE   = 8'hFF;
    localparam logic [7:0] BROADCAST_ID  = 8'hFE;
    localparam logic [7:0] OP_PING       = 8'h01;
    localparam logic [7:0] OP_READ       = 8'h02;
    localparam logic [7:0] OP_WRITE      = 8'h03;
    localparam logic [7:0] OP_SYNC_WRITE = 8'h83;
    localparam logic [7:0] GOAL_POS_ADDR = 8'h1E;
    localparam logic [7:0] TABLE_LENGTH  = 8'd49;
    localparam logic [7:0] SYNC_LENGTH   = 8'd10;
    localparam logic [7:0] SYNC_PER_ID   = 8'h02;

    // routine entry points in the microcode
    localparam logic [STEP_W-1:0] ST_HEADER = 6'd0;
    localparam logic [STEP_W-1:0] ST_PING   = 6'd2;
    localparam logic [STEP_W-1:0] ST_READ   = 6'd5;
    localparam logic [STEP_W-1:0] ST_RD_B2  = 6'd9;
    localparam logic [STEP_W-1:0] ST_RD_W2  = 6'd10;
    localparam logic [STEP_W-1:0] ST_WRITE  = 6'd11;
    localparam logic [STEP_W-1:0] ST_WR_W   = 6'd16;
    localparam logic [STEP_W-1:0] ST_TABLE  = 6'd21;
    localparam logic [STEP_W-1:0] ST_SYNC   = 6'd26;
    localparam logic [STEP_W-1:0] ST_CSUM   = 6'd37;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  servo_id;
        logic [7:0]  address;
        logic [15:0] value;
        logic [15:0] shoulder_position;
        logic [15:0] elbow_position;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_JUMP_WIDE,
        SEQ_DISPATCH,
        SEQ_END
    } t_seq;

    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_ID,
        SRC_ADDR,
        SRC_VAL_LO,
        SRC_VAL_HI,
        SRC_SH_ID,
        SRC_SH_LO,
        SRC_SH_HI,
        SRC_EL_ID,
        SRC_EL_LO,
        SRC_EL_HI,
        SRC_CSUM
    } t_src;

    typedef struct packed {
        t_seq              seq;
        logic [STEP_W-1:0] target;
        t_src              src;
        logic [7:0]        konst;
        logic              sum_clr;
        logic              sum_add;
        logic              last;
    } t_uword;

    // datapath control for one cycle
    typedef struct packed {
        logic       emit;
        t_src       src;
        logic [7:0] konst;
        logic       sum_clr;
        logic       sum_add;
        logic       last;
    } t_dp_ctrl;

    function automatic t_uword uw(t_seq seq, logic [STEP_W-1:0] target, t_src src,
                                  logic [7:0] konst, logic sum_clr, logic sum_add,
                                  logic last);
        t_uword w;
        w.seq     = seq;
        w.target  = target;
        w.src     = src;
        w.konst   = konst;
        w.sum_clr = sum_clr;
        w.sum_add = sum_add;
        w.last    = last;
        return w;
    endfunction

    // body byte, falls through
    function automatic t_uword body(t_src src, logic [7:0] konst);
        return uw(SEQ_NEXT, ST_HEADER, src, konst, 1'b0, 1'b1, 1'b0);
    endfunction

    // body byte, then jump to the checksum step
    function automatic t_uword body_cs(t_src src, logic [7:0] konst);
        return uw(SEQ_JUMP, ST_CSUM, src, konst, 1'b0, 1'b1, 1'b0);
    endfunction

    function automatic t_uword ucode(logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            6'd0:  w = uw(SEQ_NEXT, ST_HEADER, SRC_CONST, HEADER_BYTE, 1'b1, 1'b0, 1'b0);
            6'd1:  w = uw(SEQ_DISPATCH, ST_HEADER, SRC_CONST, HEADER_BYTE, 1'b0, 1'b0, 1'b0);
            // ping
            6'd2:  w = body(SRC_ID, 8'h00);
            6'd3:  w = body(SRC_CONST, 8'd2);
            6'd4:  w = body_cs(SRC_CONST, OP_PING);
            // read byte / read word
            6'd5:  w = body(SRC_ID, 8'h00);
            6'd6:  w = body(SRC_CONST, 8'd4);
            6'd7:  w = body(SRC_CONST, OP_READ);
            6'd8:  w = uw(SEQ_JUMP_WIDE, ST_RD_W2, SRC_ADDR, 8'h00, 1'b0, 1'b1, 1'b0);
            6'd9:  w = body_cs(SRC_CONST, 8'd1);
            6'd10: w = body_cs(SRC_CONST, 8'd2);
            // write byte
            6'd11: w = uw(SEQ_JUMP_WIDE, ST_WR_W, SRC_ID, 8'h00, 1'b0, 1'b1, 1'b0);
            6'd12: w = body(SRC_CONST, 8'd4);
            6'd13: w = body(SRC_CONST, OP_WRITE);
            6'd14: w = body(SRC_ADDR, 8'h00);
            6'd15: w = body_cs(SRC_VAL_LO, 8'h00);
            // write word (id already sent)
            6'd16: w = body(SRC_CONST, 8'd5);
            6'd17: w = body(SRC_CONST, OP_WRITE);
            6'd18: w = body(SRC_ADDR, 8'h00);
            6'd19: w = body(SRC_VAL_LO, 8'h00);
            6'd20: w = body_cs(SRC_VAL_HI, 8'h00);
            // read whole control table
            6'd21: w = body(SRC_ID, 8'h00);
            6'd22: w = body(SRC_CONST, 8'd4);
            6'd23: w = body(SRC_CONST, OP_READ);
            6'd24: w = body(SRC_CONST, 8'h00);
            6'd25: w = body_cs(SRC_CONST, TABLE_LENGTH);
            // sync write of both arm goal positions
            6'd26: w = body(SRC_CONST, BROADCAST_ID);
            6'd27: w = body(SRC_CONST, SYNC_LENGTH);
            6'd28: w = body(SRC_CONST, OP_SYNC_WRITE);
            6'd29: w = body(SRC_CONST, GOAL_POS_ADDR);
            6'd30: w = body(SRC_CONST, SYNC_PER_ID);
            6'd31: w = body(SRC_SH_ID, 8'h00);
            6'd32: w = body(SRC_SH_LO, 8'h00);
            6'd33: w = body(SRC_SH_HI, 8'h00);
            6'd34: w = body(SRC_EL_ID, 8'h00);
            6'd35: w = body(SRC_EL_LO, 8'h00);
            6'd36: w = body(SRC_EL_HI, 8'h00);
            // checksum closes every packet
            6'd37: w = uw(SEQ_END, ST_HEADER, SRC_CSUM, 8'h00, 1'b0, 1'b0, 1'b1);
            default: w = uw(SEQ_END, ST_HEADER, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] entry(logic [2:0] kind);
        logic [STEP_W-1:0] e;
        unique case (kind)
            KIND_PING:       e = ST_PING;
            KIND_READ_BYTE:  e = ST_READ;
            KIND_READ_WORD:  e = ST_READ;
            KIND_WRITE_BYTE: e = ST_WRITE;
            KIND_WRITE_WORD: e = ST_WRITE;
            KIND_READ_TABLE: e = ST_TABLE;
            KIND_SYNC_ARM:   e = ST_SYNC;
            default:         e = ST_CSUM;
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/sipf_sequencer.sv -----
// Microcode sequencer of the framer: step counter, ROM fetch, jumps.
// Depends on sipf_pkg.
module sipf_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [2:0]         i_kind,
    output logic               o_busy,
    output sipf_pkg::t_dp_ctrl o_ctrl
);
    import sipf_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [2:0]        r_kind;
    t_uword            w_word;
    logic              w_wide;

    assign w_word = ucode(r_step);
    assign w_wide = (r_kind == KIND_READ_WORD) || (r_kind == KIND_WRITE_WORD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_HEADER;
            r_kind <= KIND_PING;
        end else if (i_load) begin
            // unused kind: taken but framed as nothing
            r_busy <= (i_kind != KIND_NONE);
            r_step <= ST_HEADER;
            r_kind <= i_kind;
        end else if (r_busy) begin
            unique case (w_word.seq)
                SEQ_NEXT:      r_step <= r_step + 1'b1;
                SEQ_JUMP:      r_step <= w_word.target;
                SEQ_JUMP_WIDE: r_step <= w_wide ? w_word.target : r_step + 1'b1;
                SEQ_DISPATCH:  r_step <= entry(r_kind);
                SEQ_END:       r_busy <= 1'b0;
                default:       r_busy <= 1'b0;
            endcase
        end
    end

    assign o_busy          = r_busy;
    assign o_ctrl.emit     = r_busy;
    assign o_ctrl.src      = w_word.src;
    assign o_ctrl.konst    = w_word.konst;
    assign o_ctrl.sum_clr  = w_word.sum_clr;
    assign o_ctrl.sum_add  = w_word.sum_add;
    assign o_ctrl.last     = w_word.last;

endmodule

// ----- rtl/sipf_datapath.sv -----
// Byte datapath of the framer: command and id registers, byte select,
// running checksum and the result register. Depends on sipf_pkg.
module sipf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  sipf_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [sipf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sipf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  sipf_pkg::t_dp_ctrl                  i_ctrl,
    output logic                                o_res_valid,
    output sipf_pkg::t_res                      o_res
);
    import sipf_pkg::*;

    t_cmd       r_cmd;
    logic [7:0] r_shoulder_id;
    logic [7:0] r_elbow_id;
    logic [7:0] r_sum;
    logic [7:0] w_byte;
    logic       r_valid;
    t_res       r_res;

    always_comb begin
        unique case (i_ctrl.src)
            SRC_CONST:  w_byte = i_ctrl.konst;
            SRC_ID:     w_byte = r_cmd.servo_id;
            SRC_ADDR:   w_byte = r_cmd.address;
            SRC_VAL_LO: w_byte = r_cmd.value[7:0];
            SRC_VAL_HI: w_byte = r_cmd.value[15:8];
            SRC_SH_ID:  w_byte = r_shoulder_id;
            SRC_SH_LO:  w_byte = r_cmd.shoulder_position[7:0];
            SRC_SH_HI:  w_byte = r_cmd.shoulder_position[15:8];
            SRC_EL_ID:  w_byte = r_elbow_id;
            SRC_EL_LO:  w_byte = r_cmd.elbow_position[7:0];
            SRC_EL_HI:  w_byte = r_cmd.elbow_position[15:8];
            SRC_CSUM:   w_byte = ~r_sum;
            default:    w_byte = i_ctrl.konst;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shoulder_id <= SHOULDER_ID_RST;
            r_elbow_id    <= ELBOW_ID_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SHOULDER_ID) begin
                r_shoulder_id <= i_cfg_wdata;
            end else if (i_cfg_index == CFG_ELBOW_ID) begin
                r_elbow_id <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.emit;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
        if (i_ctrl.emit) begin
            if (i_ctrl.sum_clr) begin
                r_sum <= 8'h00;
            end else if (i_ctrl.sum_add) begin
                r_sum <= r_sum + w_byte;
            end
            r_res.out_byte <= w_byte;
            r_res.last     <= i_ctrl.last;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/servo_instruction_packet_framer.sv -----
// Top level of the servo-bus instruction packet framer.
// Depends on sipf_pkg, sipf_sequencer, sipf_datapath and assert_macros.svh.
//
// A request is taken at a clock edge with i_start high and o_busy low.
// The framer then sends the packet FF FF id length instruction params
// checksum, one byte per clock, each byte on o_res for exactly one
// cycle with o_res_valid high; o_res.last marks the checksum byte. The
// receiver cannot stall: it must take every byte in the cycle it shows.
// The first byte appears in the cycle after o_busy rises, since the
// result register sits behind the microcode step. A packet of N bytes
// (6 for ping, 8 for reads and write byte, 9 for write word, 14 for the
// sync arm write) keeps o_busy high for one microcode step per byte, and
// a new request is taken only once o_busy is low again; the checksum
// byte shows in the cycle in which o_busy falls. Kind 7 is taken but
// sends nothing and does not raise o_busy. The shoulder and elbow ids of
// the sync write are set through the write port (index 0 and 1, reset 1
// and 2); write them only while the framer is idle.
module servo_instruction_packet_framer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  sipf_pkg::t_cmd                      i_cmd,
    output logic                                o_busy,
    input  logic                                i_cfg_we,
    input  logic [sipf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sipf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_res_valid,
    output sipf_pkg::t_res                      o_res
);
    import sipf_pkg::*;

    `include "assert_macros.svh"

    logic     w_accept;
    t_dp_ctrl w_ctrl;

    assign w_accept = i_start && !o_busy;

    // control: microcode ROM walked by a step counter
    sipf_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_kind  (i_cmd.kind),
        .o_busy  (o_busy),
        .o_ctrl  (w_ctrl)
    );

    // data: byte select, checksum, result register, id registers
    sipf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (w_ctrl),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // a request with a real kind starts a packet
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_accept && (i_cmd.kind != KIND_NONE), o_busy)
    // a byte only follows a cycle of sequencer work
    `ASSERT_IMPL(a_valid_from_busy, i_clk, i_rst_n, o_res_valid, $past(o_busy))
    // the checksum byte shows as the sequencer goes idle
    `ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, o_res_valid && o_res.last, !o_busy)

endmodule

// ----- sim/servo_instruction_packet_framer_tb.sv -----
// Self-checking testbench for the servo instruction packet framer.
// Depends on sipf_pkg and servo_instruction_packet_framer; predicts every
// packet byte from the request and the arm ids, then checks it on the fly.
module servo_instruction_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sipf_pkg::*;

    // Cycles of silence to let a packet in flight finish before a
    // register write or the end of the run (longest packet is 14 bytes).
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    // Register indexes with no register behind them; writes are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // One queued sender action: a command request or a register write.
    typedef struct {
        bit                    is_cfg;
        bit                    drain;   // hold off until every byte is out
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        t_cmd                  cmd;
        int unsigned           gap;     // idle cycles after acceptance
    } t_req;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_cmd                  i_cmd       = '0;
    logic                  o_busy;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_res_valid;
    t_res                  o_res;

    t_req        req_pending[$];
    t_res        bytes_due[$];
    logic [7:0]  shoulder_id_cfg = SHOULDER_ID_RST;
    logic [7:0]  elbow_id_cfg    = ELBOW_ID_RST;
    int unsigned gap_left        = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;

    servo_instruction_packet_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Expected packet for one accepted request: two header bytes, the body,
    // then the inverted low byte of the body sum, flagged as last.
    function automatic void frame_request(t_cmd c);
        logic [7:0] body[$];
        logic [7:0] sum;
        case (c.kind)
            KIND_PING:       body = {c.servo_id, 8'd2, OP_PING};
            KIND_READ_BYTE:  body = {c.servo_id, 8'd4, OP_READ, c.address, 8'd1};
            KIND_READ_WORD:  body = {c.servo_id, 8'd4, OP_READ, c.address, 8'd2};
            KIND_WRITE_BYTE: body = {c.servo_id, 8'd4, OP_WRITE, c.address, c.value[7:0]};
            KIND_WRITE_WORD: body = {c.servo_id, 8'd5, OP_WRITE, c.address,
                                     c.value[7:0], c.value[15:8]};
            KIND_READ_TABLE: body = {c.servo_id, 8'd4, OP_READ, 8'h00, TABLE_LENGTH};
            KIND_SYNC_ARM:   body = {BROADCAST_ID, SYNC_LENGTH, OP_SYNC_WRITE,
                                     GOAL_POS_ADDR, SYNC_PER_ID,
                                     shoulder_id_cfg, c.shoulder_position[7:0],
                                     c.shoulder_position[15:8],
                                     elbow_id_cfg, c.elbow_position[7:0],
                                     c.elbow_position[15:8]};
            default:         return;   // unused kind: no packet at all
        endcase
        bytes_due.push_back(t_res'{HEADER_BYTE, 1'b0});
        bytes_due.push_back(t_res'{HEADER_BYTE, 1'b0});
        sum = 8'h00;
        foreach (body[i]) begin
            sum += body[i];
            bytes_due.push_back(t_res'{body[i], 1'b0});
        end
        bytes_due.push_back(t_res'{~sum, 1'b1});
    endfunction

    function automatic t_cmd mk_cmd(logic [2:0] kind, logic [7:0] id, logic [7:0] addr,
                                    logic [15:0] value, logic [15:0] sh,
                                    logic [15:0] el);
        t_cmd c;
        c.kind              = kind;
        c.servo_id          = id;
        c.address           = addr;
        c.value             = value;
        c.shoulder_position = sh;
        c.elbow_position    = el;
        return c;
    endfunction

    task automatic add_cmd(t_cmd c, int unsigned gap, bit drain);
        t_req r;
        r        = '{default: '0};
        r.cmd    = c;
        r.gap    = gap;
        r.drain  = drain;
        req_pending.push_back(r);
    endtask

    // Register writes always wait for the framer to go quiet.
    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_req r;
        r          = '{default: '0};
        r.is_cfg   = 1'b1;
        r.drain    = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        req_pending.push_back(r);
    endtask

    // Driver: holds a request until it is taken (start high, busy low),
    // then idles for the request's gap before presenting the next one.
    always @(posedge i_clk) begin
        logic                  start_n;
        t_cmd                  cmd_n;
        logic                  we_n;
        logic [CFG_IDX_W-1:0]  idx_n;
        logic [CFG_DATA_W-1:0] wdata_n;
        t_req                  r;
        start_n = i_rst_n && i_start && o_busy;
        cmd_n   = i_cmd;
        we_n    = 1'b0;
        idx_n   = i_cfg_index;
        wdata_n = i_cfg_wdata;
        if (i_rst_n && !start_n) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (req_pending.size() != 0 &&
                         (!req_pending[0].drain || quiet_cycles >= DRAIN_CYCLES)) begin
                r = req_pending.pop_front();
                if (r.is_cfg) begin
                    we_n    = 1'b1;
                    idx_n   = r.cfg_idx;
                    wdata_n = r.cfg_data;
                end else begin
                    start_n = 1'b1;
                    cmd_n   = r.cmd;
                end
                gap_left = r.gap;
            end
        end
        i_start     <= start_n;
        i_cmd       <= cmd_n;
        i_cfg_we    <= we_n;
        i_cfg_index <= idx_n;
        i_cfg_wdata <= wdata_n;
    end

    // Monitor: tracks register writes, predicts on each accepted request and
    // checks every strobed byte against the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            shoulder_id_cfg = SHOULDER_ID_RST;
            elbow_id_cfg    = ELBOW_ID_RST;
            quiet_cycles    = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SHOULDER_ID)
                    shoulder_id_cfg = i_cfg_wdata;
                else if (i_cfg_index == CFG_ELBOW_ID)
                    elbow_id_cfg = i_cfg_wdata;
            end
            if (i_start && !o_busy)
                frame_request(i_cmd);
            if (o_res_valid) begin
                if (bytes_due.size() == 0) begin
                    $error("unexpected packet byte %h (last %b)", o_res.out_byte, o_res.last);
                    fail_count++;
                end else begin
                    want = bytes_due.pop_front();
                    if (o_res.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, o_res.out_byte);
                        fail_count++;
                    end
                    if (o_res.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_res.last);
                        fail_count++;
                    end
                end
            end
            // quiet means nothing owed, nothing in flight, nothing offered
            if (bytes_due.size() == 0 && !o_busy && !i_start && !i_cfg_we)
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [2:0]  kind;
        int unsigned gap;
        bit          drain;

        // directed: field extremes under the reset arm ids, back to back
        add_cmd(mk_cmd(KIND_PING, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 0, 0);
        add_cmd(mk_cmd(KIND_PING, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_READ_BYTE, 8'h01, 8'h00, 16'hFFFF, 16'h0000, 16'h0000), 0, 0);
        add_cmd(mk_cmd(KIND_READ_BYTE, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_READ_WORD, 8'hFE, 8'h7F, 16'h5A5A, 16'h0000, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_WRITE_BYTE, 8'h03, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000), 0, 0);
        add_cmd(mk_cmd(KIND_WRITE_BYTE, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_WRITE_WORD, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000), 0, 0);
        add_cmd(mk_cmd(KIND_WRITE_WORD, 8'h10, 8'h1E, 16'h12AB, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_READ_TABLE, 8'h10, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h22, 8'h33, 16'h4455, 16'h0000, 16'hFFFF), 0, 0);
        // unused kind between two packets: must produce nothing
        add_cmd(mk_cmd(KIND_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'h0000), 0, 0);
        // arm id extremes, then the reserved ids passed straight through
        add_cfg(CFG_SHOULDER_ID, 8'd0);
        add_cfg(CFG_ELBOW_ID, 8'd253);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h00, 8'h00, 16'h0000, 16'h1234, 16'hABCD), 0, 0);
        add_cfg(CFG_SHOULDER_ID, 8'd253);
        add_cfg(CFG_ELBOW_ID, 8'd0);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF), 0, 0);
        add_cfg(CFG_SHOULDER_ID, BROADCAST_ID);
        add_cfg(CFG_ELBOW_ID, HEADER_BYTE);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h00, 8'h00, 16'h0000, 16'h8001, 16'h7FFE), 0, 0);
        // writes to indexes with no register behind them change nothing
        add_cfg(CFG_SPARE_A, 8'hAA);
        add_cfg(CFG_SPARE_B, 8'h55);
        add_cmd(mk_cmd(KIND_SYNC_ARM, 8'h00, 8'h00, 16'h0000, 16'h00FF, 16'hFF00), 0, 0);
        add_cmd(mk_cmd(KIND_NONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 0, 0);
        add_cmd(mk_cmd(KIND_PING, BROADCAST_ID, 8'h00, 16'h0000, 16'h0000, 16'h0000), 0, 0);

        // random: four register settings, each followed by a run of requests
        for (int ph = 0; ph < 4; ph++) begin
            add_cfg(CFG_SHOULDER_ID, 8'($urandom));
            add_cfg(CFG_ELBOW_ID, 8'($urandom));
            if ($urandom_range(0, 1) != 0)
                add_cfg($urandom_range(0, 1) != 0 ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));
            for (int k = 0; k < 23; k++) begin
                kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : 3'($urandom_range(0, 6));
                // idle bursts, but none in the closing stretch
                if (ph == 3 && k >= 10)
                    gap = 0;
                else if ($urandom_range(0, 2) == 0)
                    gap = $urandom_range(1, 15);
                else
                    gap = 0;
                // sender hold-off until the framer has drained
                drain = (ph == 1 && k == 15) ||
                        (!(ph == 3 && k >= 10) && $urandom_range(0, 24) == 0);
                add_cmd(mk_cmd(kind, 8'($urandom), 8'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom)), gap, drain);
            end
        end

        do @(posedge i_clk);
        while (!(req_pending.size() == 0 && !i_start && bytes_due.size() == 0 && !o_busy));
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && bytes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- servo_instruction_packet_framer.f -----
+incdir+rtl
rtl/sipf_pkg.sv
rtl/sipf_sequencer.sv
rtl/sipf_datapath.sv
rtl/servo_instruction_packet_framer.sv
sim/servo_instruction_packet_framer_tb.sv
